/* design/gpio_mux_pkg.sv */
// Package for the GPIO pin mux with overrides: command and override codes,
// function select codes, transaction layouts and the override helper.
// No dependencies.
`timescale 1ns / 1ps

package gpio_mux_pkg;

    // Pins carried on the all-pins result buses.
    localparam int BUS_PINS     = 30;
    localparam int NUM_PINS_DEF = 30;
    localparam int NUM_DRIVERS  = 4;
    localparam int PIN_W        = 5;
    localparam int FUNC_W       = 5;

    typedef enum logic [2:0] {
        CMD_QUERY     = 3'd0,
        CMD_FUNCSEL   = 3'd1,
        CMD_PULLS     = 3'd2,
        CMD_OVERRIDES = 3'd3,
        CMD_DRV_OUT   = 3'd4,
        CMD_DRV_OE    = 3'd5,
        CMD_EXT_SET   = 3'd6,
        CMD_EXT_CLR   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        OVR_NORMAL = 2'd0,
        OVR_INVERT = 2'd1,
        OVR_LOW    = 2'd2,
        OVR_HIGH   = 2'd3
    } ovr_t;

    // Driver slots, in the order the driver field encodes them.
    localparam logic [1:0] DRV_SIO  = 2'd0;
    localparam logic [1:0] DRV_PIO0 = 2'd1;
    localparam logic [1:0] DRV_PIO1 = 2'd2;
    localparam logic [1:0] DRV_PWM  = 2'd3;

    localparam logic [FUNC_W-1:0] FUNC_PWM  = 5'd4;
    localparam logic [FUNC_W-1:0] FUNC_SIO  = 5'd5;
    localparam logic [FUNC_W-1:0] FUNC_PIO0 = 5'd6;
    localparam logic [FUNC_W-1:0] FUNC_PIO1 = 5'd7;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 5'd31;

    // Command transaction, first field in the highest bits.
    typedef struct packed {
        ovr_t              irq_override;
        ovr_t              in_override;
        ovr_t              oe_override;
        ovr_t              out_override;
        logic              pull_dn;
        logic              pull_up;
        logic [FUNC_W-1:0] function_select;
        logic              value_bit;
        logic [1:0]        driver;
        logic [PIN_W-1:0]  pin;
        cmd_t              cmd;
    } cmd_item_t;

    // Result transaction, first field in the highest bits.
    typedef struct packed {
        logic [BUS_PINS-1:0] all_function_inputs;
        logic [BUS_PINS-1:0] all_pin_levels;
        logic                interrupt_level;
        logic                function_input_level;
        logic                pin_level;
        logic                pad_out_level;
        logic                pad_drive_enable;
        logic                pin_valid;
    } result_t;

    // Per-pin override set, stored as written by the overrides command.
    typedef struct packed {
        ovr_t irq_ovr;
        ovr_t in_ovr;
        ovr_t oe_ovr;
        ovr_t out_ovr;
    } pin_ovr_t;

    localparam int CMD_ITEM_W = $bits(cmd_item_t);
    localparam int RESULT_W   = $bits(result_t);
    localparam int S_DATA_W   = ((CMD_ITEM_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((RESULT_W + 7) / 8) * 8;

    function automatic logic apply_ovr(input ovr_t code, input logic v);
        logic r;
        case (code)
            OVR_INVERT: r = ~v;
            OVR_LOW:    r = 1'b0;
            OVR_HIGH:   r = 1'b1;
            default:    r = v;
        endcase
        return r;
    endfunction

endpackage

/* design/gpio_pin_mux_override.sv */
// GPIO bank with per-pin function mux, pulls, external drive and overrides.
// Depends on gpio_mux_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave channel (s_t*): one command per transaction (query, function select,
//   pulls, overrides, driver output bit, driver output-enable bit, set or clear
//   external drive). Commands addressing a pin at or above NUM_PINS change
//   nothing and report zeros for the addressed-pin fields.
//   Master channel (m_t*): exactly one result transaction per command: the
//   addressed pin's pad enable, pad output, level, function input and
//   interrupt level after the update, plus the level and function input of
//   pins 0 to 29.
//   Throughput: one command per cycle while m_tready stays high. The state
//   update happens at the accepting edge, which also loads the command stage;
//   all pins then resolve in parallel into the result register, which drives
//   m_tdata.
//   Stall: the result register holds while m_tready is low; the command stage
//   behind it holds too, and s_tready drops only when both are full, so no
//   state changes while a command waits.
//   Reset (aresetn low, synchronous): both stages empty, every pin gets no
//   function, no pulls, normal overrides, no external drive; driver bits clear.
module gpio_pin_mux_override
    import gpio_mux_pkg::*;
#(
    parameter int NUM_PINS = NUM_PINS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata, from bit 0: cmd[2:0], pin[7:3], driver[9:8], value_bit[10],
    // function_select[15:11], pull_up[16], pull_dn[17], out_override[19:18],
    // oe_override[21:20], in_override[23:22], irq_override[25:24], zero fill
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // m_tdata, from bit 0: pin_valid[0], pad_drive_enable[1], pad_out_level[2],
    // pin_level[3], function_input_level[4], interrupt_level[5],
    // all_pin_levels[35:6], all_function_inputs[65:36], zero fill
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    cmd_item_t item;
    logic      accept;
    logic      advance;

    // Command stage: only the pin number travels on; the update is already in
    // the state registers once the command is accepted.
    logic             cmd_vld_reg;
    logic             cmd_vld_next;
    logic [PIN_W-1:0] pin_reg;

    // Result stage
    logic    res_vld_reg;
    logic    res_vld_next;
    result_t res_reg;
    result_t res_next;

    // Pin and driver state
    logic [FUNC_W-1:0]   func_reg    [NUM_PINS];
    pin_ovr_t            ovr_reg     [NUM_PINS];
    logic [NUM_PINS-1:0] pull_up_reg;
    logic [NUM_PINS-1:0] pull_dn_reg;
    logic [NUM_PINS-1:0] ext_drv_reg;
    logic [NUM_PINS-1:0] ext_lvl_reg;
    logic [NUM_PINS-1:0] drv_out_reg [NUM_DRIVERS];
    logic [NUM_PINS-1:0] drv_oe_reg  [NUM_DRIVERS];

    // Per-pin resolved values
    logic [NUM_PINS-1:0] pad_en;
    logic [NUM_PINS-1:0] pad_out;
    logic [NUM_PINS-1:0] level;
    logic [NUM_PINS-1:0] fn_in;
    logic [NUM_PINS-1:0] irq_lvl;

    assign item = cmd_item_t'(s_tdata[CMD_ITEM_W-1:0]);

    // Handshake: the command stage moves on when the result register is free
    // or being emptied; accept a new command whenever the command stage will
    // be free at this edge.
    assign advance      = cmd_vld_reg && (!res_vld_reg || m_tready);
    assign s_tready     = !cmd_vld_reg || advance;
    assign accept       = s_tvalid && s_tready;
    assign cmd_vld_next = accept || (cmd_vld_reg && !advance);
    assign res_vld_next = advance || (res_vld_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            cmd_vld_reg <= cmd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pin_reg <= item.pin;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Apply the accepted command to the addressed pin; out-of-range pins
    // match no slot and so change nothing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PINS; i++) begin
                func_reg[i] <= FUNC_NONE;
                ovr_reg[i]  <= '{OVR_NORMAL, OVR_NORMAL, OVR_NORMAL, OVR_NORMAL};
            end
            pull_up_reg <= '0;
            pull_dn_reg <= '0;
            ext_drv_reg <= '0;
            ext_lvl_reg <= '0;
            for (int d = 0; d < NUM_DRIVERS; d++) begin
                drv_out_reg[d] <= '0;
                drv_oe_reg[d]  <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < NUM_PINS; i++) begin
                if (item.pin == PIN_W'(i)) begin
                    unique case (item.cmd)
                        CMD_FUNCSEL: begin
                            func_reg[i] <= item.function_select;
                        end
                        CMD_PULLS: begin
                            pull_up_reg[i] <= item.pull_up;
                            pull_dn_reg[i] <= item.pull_dn;
                        end
                        CMD_OVERRIDES: begin
                            ovr_reg[i] <= '{item.irq_override, item.in_override,
                                            item.oe_override, item.out_override};
                        end
                        CMD_DRV_OUT: begin
                            drv_out_reg[item.driver][i] <= item.value_bit;
                        end
                        CMD_DRV_OE: begin
                            drv_oe_reg[item.driver][i] <= item.value_bit;
                        end
                        CMD_EXT_SET: begin
                            ext_drv_reg[i] <= 1'b1;
                            ext_lvl_reg[i] <= item.value_bit;
                        end
                        CMD_EXT_CLR: begin
                            // keep the stored external level
                            ext_drv_reg[i] <= 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Resolve every pin in parallel: function mux, pad overrides, then the
    // level priority pad > external > pull-up > pull-down > low.
    always_comb begin
        logic sel_oe;
        logic sel_out;
        for (int i = 0; i < NUM_PINS; i++) begin
            unique case (func_reg[i])
                FUNC_SIO: begin
                    sel_oe  = drv_oe_reg[DRV_SIO][i];
                    sel_out = drv_out_reg[DRV_SIO][i];
                end
                FUNC_PIO0: begin
                    sel_oe  = drv_oe_reg[DRV_PIO0][i];
                    sel_out = drv_out_reg[DRV_PIO0][i];
                end
                FUNC_PIO1: begin
                    sel_oe  = drv_oe_reg[DRV_PIO1][i];
                    sel_out = drv_out_reg[DRV_PIO1][i];
                end
                FUNC_PWM: begin
                    sel_oe  = drv_oe_reg[DRV_PWM][i];
                    sel_out = drv_out_reg[DRV_PWM][i];
                end
                default: begin
                    sel_oe  = 1'b0;
                    sel_out = 1'b0;
                end
            endcase
            pad_en[i]  = apply_ovr(ovr_reg[i].oe_ovr, sel_oe);
            pad_out[i] = apply_ovr(ovr_reg[i].out_ovr, sel_out);
            if (pad_en[i]) begin
                level[i] = pad_out[i];
            end else if (ext_drv_reg[i]) begin
                level[i] = ext_lvl_reg[i];
            end else if (pull_up_reg[i]) begin
                level[i] = 1'b1;
            end else if (pull_dn_reg[i]) begin
                level[i] = 1'b0;
            end else begin
                level[i] = 1'b0;
            end
            fn_in[i]   = apply_ovr(ovr_reg[i].in_ovr, level[i]);
            irq_lvl[i] = apply_ovr(ovr_reg[i].irq_ovr, level[i]);
        end
    end

    // Bus fields cover pins 0..BUS_PINS-1; bits for absent pins read zero.
    logic [BUS_PINS-1:0] bus_lvl;
    logic [BUS_PINS-1:0] bus_fn;

    for (genvar b = 0; b < BUS_PINS; b++) begin : g_bus
        if (b < NUM_PINS) begin : g_pin
            assign bus_lvl[b] = level[b];
            assign bus_fn[b]  = fn_in[b];
        end else begin : g_none
            assign bus_lvl[b] = 1'b0;
            assign bus_fn[b]  = 1'b0;
        end
    end

    // Pick the addressed pin; an out-of-range pin leaves the addressed-pin fields zero.
    always_comb begin
        res_next                     = '0;
        res_next.all_pin_levels      = bus_lvl;
        res_next.all_function_inputs = bus_fn;
        for (int i = 0; i < NUM_PINS; i++) begin
            if (pin_reg == PIN_W'(i)) begin
                res_next.pin_valid            = 1'b1;
                res_next.pad_drive_enable     = pad_en[i];
                res_next.pad_out_level        = pad_out[i];
                res_next.pin_level            = level[i];
                res_next.function_input_level = fn_in[i];
                res_next.interrupt_level      = irq_lvl[i];
            end
        end
    end

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, res_reg};

endmodule
